[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion helpers shared by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/chps_pkg.sv]
// ---------------------------------------------------------------------------
// chps_pkg
// constants, tables and types for the charlieplexed segment scanner
// ---------------------------------------------------------------------------
package chps_pkg;

    localparam int SEGMENT_COUNT = 18;
    localparam int PIN_COUNT     = 5;
    localparam int SEG_W         = 5;
    localparam int PIN_IDX_W     = 3;
    localparam int NUM_W         = 7;
    localparam int IND_W         = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = NUM_W;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 16;

    localparam logic [SEG_W-1:0] POS_NONE   = 5'd31;
    localparam logic [SEG_W-1:0] SEG_LAST   = 5'(SEGMENT_COUNT - 1);
    localparam logic [NUM_W-1:0] NUMBER_MAX = 7'd100;
    localparam logic [NUM_W-1:0] NUMBER_TEN = 7'd10;

    // tens = (n * 205) >> 11, exact for n in 0..100
    localparam logic [7:0] TENS_RECIP = 8'd205;
    localparam int         TENS_SHIFT = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISPLAY_NUMBER = 2'd0,
        CFG_INDICATOR_BITS = 2'd1
    } t_cfg_reg;

    typedef logic [SEGMENT_COUNT-1:0] t_seg_mask;

    typedef struct packed {
        logic [PIN_IDX_W-1:0] hi;
        logic [PIN_IDX_W-1:0] lo;
    } t_route;

    // abcdefg in bits 0..6
    function automatic logic [6:0] digit_pattern(input logic [3:0] d);
        logic [6:0] p;
        case (d)
            4'd0:    p = 7'h3F;
            4'd1:    p = 7'h06;
            4'd2:    p = 7'h5B;
            4'd3:    p = 7'h4F;
            4'd4:    p = 7'h66;
            4'd5:    p = 7'h6D;
            4'd6:    p = 7'h7D;
            4'd7:    p = 7'h07;
            4'd8:    p = 7'h7F;
            4'd9:    p = 7'h6F;
            default: p = 7'h00;
        endcase
        return p;
    endfunction

    // pin pair wired to each segment
    function automatic t_route seg_route(input logic [SEG_W-1:0] s);
        t_route r;
        case (s)
            5'd0:    r = '{hi: 3'd1, lo: 3'd2};
            5'd1:    r = '{hi: 3'd2, lo: 3'd1};
            5'd2:    r = '{hi: 3'd3, lo: 3'd2};
            5'd3:    r = '{hi: 3'd3, lo: 3'd1};
            5'd4:    r = '{hi: 3'd4, lo: 3'd1};
            5'd5:    r = '{hi: 3'd4, lo: 3'd2};
            5'd6:    r = '{hi: 3'd4, lo: 3'd3};
            5'd7:    r = '{hi: 3'd0, lo: 3'd1};
            5'd8:    r = '{hi: 3'd1, lo: 3'd0};
            5'd9:    r = '{hi: 3'd0, lo: 3'd2};
            5'd10:   r = '{hi: 3'd2, lo: 3'd0};
            5'd11:   r = '{hi: 3'd0, lo: 3'd3};
            5'd12:   r = '{hi: 3'd3, lo: 3'd0};
            5'd13:   r = '{hi: 3'd4, lo: 3'd0};
            5'd14:   r = '{hi: 3'd2, lo: 3'd3};
            5'd15:   r = '{hi: 3'd1, lo: 3'd3};
            5'd16:   r = '{hi: 3'd2, lo: 3'd4};
            5'd17:   r = '{hi: 3'd1, lo: 3'd4};
            default: r = '{hi: 3'd0, lo: 3'd0};
        endcase
        return r;
    endfunction

endpackage

[rtl/core/charlieplex_segment_scanner.sv]
// ---------------------------------------------------------------------------
// charlieplex_segment_scanner
// round-robin scanner for an 18-segment charlieplexed display on 5 pins
// ---------------------------------------------------------------------------
// usage
//   config port: i_cfg_we / i_cfg_idx / i_cfg_data. index 0 is the display
//   number (clamped to 100), index 1 the four indicator bits. write only
//   while no word is in flight.
//   input stream: one tick word per scan period, tick in tdata bit 0.
//   a set tick steps to the next active segment after the last one lit,
//   a clear tick repeats the current one.
//   output stream: one result word per input word with the pin drive mask,
//   the pin levels, a lit flag and the lit segment index.
//   path: a word taken into the input register passes the rotate and
//   find-first pass into the result register. throughput: one word every
//   cycle while the output is not stalled, set by that single pass.
//   stall: the input register and the result register form two stages, so
//   one word is still taken while a result waits; further words wait.
//   reset: config is cleared, the scan points at no segment so the first
//   set tick starts the search at segment 0, both stages are empty.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module charlieplex_segment_scanner (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write port
    input  logic                               i_cfg_we,
    input  logic [chps_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [chps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [chps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [0] tick
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [chps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // [4:0] pin_drive,
                                                              // [9:5] pin_high,
                                                              // [10] lit,
                                                              // [15:11] segment_lit
);

    // configuration
    logic [chps_pkg::NUM_W-1:0] r_number;
    logic [chps_pkg::IND_W-1:0] r_indicator;
    logic [chps_pkg::NUM_W-1:0] w_cfg_num;

    assign w_cfg_num = (i_cfg_data > chps_pkg::NUMBER_MAX) ? chps_pkg::NUMBER_MAX
                                                            : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number    <= '0;
            r_indicator <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                chps_pkg::CFG_DISPLAY_NUMBER: r_number    <= w_cfg_num;
                chps_pkg::CFG_INDICATOR_BITS: r_indicator <= i_cfg_data[chps_pkg::IND_W-1:0];
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    // pipeline handshake
    logic r_in_valid;
    logic r_in_tick;
    logic r_out_valid;
    logic w_advance;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // input register, payload only
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_tick <= s_axis_tdata[0];
        end
    end

    // active segment mask from the config
    logic [14:0]                   w_prod;
    logic [3:0]                    w_tens_full;
    logic [3:0]                    w_tens;
    logic [chps_pkg::NUM_W-1:0]    w_ones_full;
    chps_pkg::t_seg_mask           w_mask;
    logic [chps_pkg::IND_W-1:0]    w_marks;

    always_comb begin
        w_prod      = 15'(r_number) * 15'(chps_pkg::TENS_RECIP);
        w_tens_full = w_prod[chps_pkg::TENS_SHIFT +: 4];
        // only 100 gives ten tens; the tens digit then shows zero
        w_tens      = (w_tens_full == 4'd10) ? 4'd0 : w_tens_full;
        w_ones_full = r_number - (7'(w_tens_full) * 7'd10);
        // hundreds mark lights H1 and H2
        w_marks     = r_indicator |
                      ((r_number >= chps_pkg::NUMBER_MAX) ? 4'b0011 : 4'b0000);
        w_mask[6:0]   = (r_number >= chps_pkg::NUMBER_TEN) ? chps_pkg::digit_pattern(w_tens)
                                                           : 7'd0;
        w_mask[13:7]  = chps_pkg::digit_pattern(w_ones_full[3:0]);
        w_mask[17:14] = w_marks;
    end

    // round-robin search: rotate so the search opens at the slot after the
    // last lit one, then take the first set bit
    logic [chps_pkg::SEG_W-1:0]         r_scan;
    logic [chps_pkg::SEG_W-1:0]         n_scan;
    logic [chps_pkg::SEG_W-1:0]         w_start;
    logic [2*chps_pkg::SEGMENT_COUNT-1:0] w_dbl;
    chps_pkg::t_seg_mask                w_rot;
    logic [chps_pkg::SEG_W-1:0]         w_first;
    logic [chps_pkg::SEG_W:0]           w_sum;
    logic [chps_pkg::SEG_W-1:0]         w_next;

    always_comb begin
        // no segment yet (or a position out of range) starts at segment 0
        if (r_scan < chps_pkg::SEG_LAST) begin
            w_start = r_scan + 5'd1;
        end else begin
            w_start = '0;
        end
        w_dbl   = {w_mask, w_mask} >> w_start;
        w_rot   = w_dbl[chps_pkg::SEGMENT_COUNT-1:0];
        w_first = '0;
        for (int k = chps_pkg::SEGMENT_COUNT - 1; k >= 0; k--) begin
            if (w_rot[k]) begin
                w_first = 5'(k);
            end
        end
        w_sum  = {1'b0, w_start} + {1'b0, w_first};
        w_next = (w_sum >= 6'(chps_pkg::SEGMENT_COUNT))
                 ? 5'(w_sum - 6'(chps_pkg::SEGMENT_COUNT)) : w_sum[chps_pkg::SEG_W-1:0];

        n_scan = r_scan;
        if (r_in_tick) begin
            n_scan = (w_mask == '0) ? chps_pkg::POS_NONE : w_next;
        end
    end

    logic w_step;
    assign w_step = r_in_valid && w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= chps_pkg::POS_NONE;
        end else if (w_step) begin
            r_scan <= n_scan;
        end
    end

    // pin pattern for the segment that is lit after this word
    chps_pkg::t_route                      w_route;
    logic                                  w_lit;
    logic [chps_pkg::PIN_COUNT-1:0]        w_high;
    logic [chps_pkg::PIN_COUNT-1:0]        w_drive;

    always_comb begin
        w_route = chps_pkg::seg_route(n_scan);
        w_lit   = (n_scan < 5'(chps_pkg::SEGMENT_COUNT));
        w_high  = w_lit ? (5'd1 << w_route.hi) : '0;
        w_drive = w_lit ? ((5'd1 << w_route.lo) | (5'd1 << w_route.hi)) : '0;
    end

    // result register, payload only
    logic [chps_pkg::PIN_COUNT-1:0] r_out_drive;
    logic [chps_pkg::PIN_COUNT-1:0] r_out_high;
    logic                           r_out_lit;
    logic [chps_pkg::SEG_W-1:0]     r_out_seg;

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_drive <= w_drive;
            r_out_high  <= w_high;
            r_out_lit   <= w_lit;
            r_out_seg   <= w_lit ? n_scan : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_seg, r_out_lit, r_out_high, r_out_drive};

    // checks
    `ASSERT_CLK(a_dark_zero, i_clk, i_rst_n,
        (r_out_valid && !r_out_lit) |-> (r_out_drive == '0 && r_out_high == '0 && r_out_seg == '0),
        "dark result carries nonzero fields")
    `ASSERT_CLK(a_two_pins, i_clk, i_rst_n,
        (r_out_valid && r_out_lit) |-> ($countones(r_out_drive) == 2 && $countones(r_out_high) == 1
                                        && (r_out_high & ~r_out_drive) == '0),
        "lit segment must drive one pin high and one low")
    `ASSERT_CLK(a_scan_range, i_clk, i_rst_n,
        (r_scan < 5'(chps_pkg::SEGMENT_COUNT)) || (r_scan == chps_pkg::POS_NONE),
        "scan position out of range")
    `ASSERT_CLK(a_hold_scan, i_clk, i_rst_n,
        !w_step |=> $stable(r_scan),
        "scan position moved without a word")

endmodule

[tb/charlieplex_segment_scanner_checker.sv]
// ---------------------------------------------------------------------------
// charlieplex_segment_scanner_checker
// watches the config port and both streams, keeps its own scan state and
// compares every result word with the predicted pin pattern
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module charlieplex_segment_scanner_checker
    import chps_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [0] tick
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,   // [4:0] pin_drive, [9:5] pin_high,
                                                // [10] lit, [15:11] segment_lit
    output int                     o_fail_count,
    output int                     o_pending
);

    // first indicator segment; hundreds light the first two
    localparam int IND_BASE = 14;

    typedef struct packed {
        logic [SEG_W-1:0]     segment;
        logic                 lit;
        logic [PIN_COUNT-1:0] level;
        logic [PIN_COUNT-1:0] drive;
    } t_pin_word;

    // abcdefg in bits 0..6
    localparam logic [6:0] GLYPH [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };
    // pin pulled low and pin pulled high for each segment
    localparam logic [PIN_IDX_W-1:0] PIN_LO [SEGMENT_COUNT] = '{
        3'd2, 3'd1, 3'd2, 3'd1, 3'd1, 3'd2, 3'd3, 3'd1, 3'd0,
        3'd2, 3'd0, 3'd3, 3'd0, 3'd0, 3'd3, 3'd3, 3'd4, 3'd4
    };
    localparam logic [PIN_IDX_W-1:0] PIN_HI [SEGMENT_COUNT] = '{
        3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd0, 3'd1,
        3'd0, 3'd2, 3'd0, 3'd3, 3'd4, 3'd2, 3'd1, 3'd2, 3'd1
    };

    logic [NUM_W-1:0] shown_number;
    logic [IND_W-1:0] shown_ind;
    logic [SEG_W-1:0] scan_seg;
    t_pin_word        pin_words_q [$];

    task automatic report_fault(input string msg);
        $display("scanner mismatch at %0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic t_seg_mask lit_mask(input logic [NUM_W-1:0] num,
                                           input logic [IND_W-1:0] ind);
        t_seg_mask m;
        int        tens;
        int        ones;
        tens = (int'(num) / 10) % 10;
        ones = int'(num) % 10;
        m = '0;
        if (num >= NUMBER_MAX) begin
            m[IND_BASE]     = 1'b1;
            m[IND_BASE + 1] = 1'b1;
        end
        // tens digit stays dark below ten
        if (num >= NUMBER_TEN) begin
            m[6:0] = GLYPH[tens];
        end
        m[13:7] = GLYPH[ones];
        m[17:14] = m[17:14] | ind;
        return m;
    endfunction

    // one scan period: step to the next lit segment when ticked, then show it
    function automatic t_pin_word scan_period(input logic tick);
        t_seg_mask        m;
        logic [SEG_W-1:0] idx;
        logic             found;
        t_pin_word        w;
        if (tick) begin
            m = lit_mask(shown_number, shown_ind);
            if (m == '0) begin
                scan_seg = POS_NONE;
            end else begin
                // from no segment the search starts at segment 0
                idx = (scan_seg < SEGMENT_COUNT) ? scan_seg : SEG_LAST;
                found = 1'b0;
                for (int k = 0; k < SEGMENT_COUNT; k++) begin
                    if (!found) begin
                        idx = (idx == SEG_LAST) ? '0 : idx + 1'b1;
                        found = m[idx];
                    end
                end
                scan_seg = idx;
            end
        end
        w = '0;
        if (scan_seg < SEGMENT_COUNT) begin
            w.drive   = (PIN_COUNT'(1) << PIN_LO[scan_seg]) | (PIN_COUNT'(1) << PIN_HI[scan_seg]);
            w.level   = PIN_COUNT'(1) << PIN_HI[scan_seg];
            w.lit     = 1'b1;
            w.segment = scan_seg;
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_pin_word got;
        t_pin_word want;
        if (!i_rst_n) begin
            shown_number = '0;
            shown_ind    = '0;
            scan_seg     = POS_NONE;
            pin_words_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_DISPLAY_NUMBER: begin
                        shown_number = (i_cfg_data > NUMBER_MAX) ? NUMBER_MAX : i_cfg_data;
                    end
                    CFG_INDICATOR_BITS: begin
                        shown_ind = i_cfg_data[IND_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // compare before pushing so a word cannot meet its own prediction
            if (i_m_tvalid && i_m_tready) begin
                got = t_pin_word'(i_m_tdata);
                if (pin_words_q.size() == 0) begin
                    report_fault($sformatf("result word %h with none expected", i_m_tdata));
                end else begin
                    want = pin_words_q.pop_front();
                    if (got.drive !== want.drive)
                        report_fault($sformatf("pin_drive %b expected %b",
                                               got.drive, want.drive));
                    if (got.level !== want.level)
                        report_fault($sformatf("pin_high %b expected %b",
                                               got.level, want.level));
                    if (got.lit !== want.lit)
                        report_fault($sformatf("lit %b expected %b", got.lit, want.lit));
                    if (got.segment !== want.segment)
                        report_fault($sformatf("segment_lit %0d expected %0d",
                                               got.segment, want.segment));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                pin_words_q.push_back(scan_period(i_s_tdata[0]));
            end
        end
        o_pending <= pin_words_q.size();
    end

endmodule

[tb/tb_charlieplex_segment_scanner.sv]
// ---------------------------------------------------------------------------
// tb_charlieplex_segment_scanner
// drives tick words into the scanner under random source and sink stalls,
// rewrites the display number and indicators between bursts while the
// pipeline is empty, and leaves the checking to the checker module
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_charlieplex_segment_scanner;
    import chps_pkg::*;

    // indexes past the last register, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    // random words per idling phase
    localparam int PHASE_WORDS = 483;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [0] tick
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [4:0] pin_drive, [9:5] pin_high,
                                                 // [10] lit, [15:11] segment_lit

    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int fail_count;
    int pending;

    // 8 ns clock
    always #4 i_clk = ~i_clk;

    charlieplex_segment_scanner i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    charlieplex_segment_scanner_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // sink side stalls, one decision per edge
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    // offer one tick word, after an optional random gap; valid stays high on
    // return so back-to-back words never drop and raise it in one step
    task automatic send_tick(input logic tick);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, tick};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // stop sending and wait until every expected result word has come back
    task automatic drain_scanner();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // two-stage pipeline, let it settle
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // new display setting, leaning on the extremes now and then
    task automatic shuffle_display();
        logic [CFG_DATA_W-1:0] num;
        int                    pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       num = '0;
            1:       num = NUMBER_MAX;
            2:       num = '1;
            default: num = CFG_DATA_W'($urandom_range(0, 127));
        endcase
        cfg_write(CFG_DISPLAY_NUMBER, num);
        cfg_write(CFG_INDICATOR_BITS, CFG_DATA_W'($urandom_range(0, 127)));
        if ($urandom_range(0, 3) == 0) begin
            cfg_write($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                      CFG_DATA_W'($urandom_range(0, 127)));
        end
    endtask

    // bursts of random ticks, the pipeline drained and the display changed
    // between bursts
    task automatic random_phase(input int src_pct, input int dst_pct);
        int sent;
        int burst;
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        sent = 0;
        while (sent < PHASE_WORDS) begin
            burst = $urandom_range(20, 80);
            // last burst trimmed so each phase sends exactly its share
            if (burst > PHASE_WORDS - sent) begin
                burst = PHASE_WORDS - sent;
            end
            repeat (burst) send_tick($urandom_range(0, 99) < 80);
            sent += burst;
            drain_scanner();
            shuffle_display();
        end
    endtask

    initial begin : stimulus
        src_idle_pct = 21;
        dst_idle_pct = 62;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // out of reset: a clear tick shows nothing, the first set tick
        // searches from segment 0 and lands on the ones digit
        send_tick(1'b0);
        repeat (3) send_tick(1'b1);
        drain_scanner();

        // hundreds mark; the clear tick still shows the old segment
        cfg_write(CFG_DISPLAY_NUMBER, NUMBER_MAX);
        cfg_write(CFG_INDICATOR_BITS, '0);
        send_tick(1'b0);
        repeat (6) send_tick(1'b1);
        drain_scanner();

        // clamp from the top of the field, all indicators on
        cfg_write(CFG_DISPLAY_NUMBER, '1);
        cfg_write(CFG_INDICATOR_BITS, '1);
        repeat (8) send_tick(1'b1);
        drain_scanner();

        // single digit drops the tens and indicators; a clear tick repeats
        // a segment that may no longer be active, spare indexes do nothing
        cfg_write(CFG_DISPLAY_NUMBER, 7'd7);
        cfg_write(CFG_INDICATOR_BITS, 7'h70);
        cfg_write(CFG_SPARE_LO, '1);
        cfg_write(CFG_SPARE_HI, 7'h55);
        send_tick(1'b0);
        repeat (4) send_tick(1'b1);
        drain_scanner();

        random_phase(21, 62);
        random_phase(62, 21);
        random_phase(0, 0);

        drain_scanner();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("charlieplex_segment_scanner regression: pass");
        end else begin
            $display("charlieplex_segment_scanner regression: fail");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin : watchdog
        #2_000_000;
        $display("charlieplex_segment_scanner regression: fail");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/chps_pkg.sv
rtl/core/charlieplex_segment_scanner.sv
tb/charlieplex_segment_scanner_checker.sv
tb/tb_charlieplex_segment_scanner.sv
